// ----- hw/rtl/keypad_setpoint_editor_macros.svh -----
// assertion macros used by the keypad setpoint editor top level
`ifndef KEYPAD_SETPOINT_EDITOR_MACROS_SVH
`define KEYPAD_SETPOINT_EDITOR_MACROS_SVH

// antecedent implies consequent in the same cycle
`define KSE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("keypad setpoint editor check failed");

// antecedent implies consequent in the next cycle
`define KSE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("keypad setpoint editor check failed");

`endif

// ----- hw/rtl/kse_pkg.sv -----
// shared types, codes and helper functions of the keypad setpoint editor
package kse_pkg;

  localparam int unsigned TableEntriesDef = 179;

  // debounced key event codes
  localparam logic [4:0] EV_NONE      = 5'h00;
  localparam logic [4:0] EV_UP        = 5'h01;
  localparam logic [4:0] EV_DOWN      = 5'h02;
  localparam logic [4:0] EV_LEFT      = 5'h03;
  localparam logic [4:0] EV_RIGHT     = 5'h04;
  localparam logic [4:0] EV_ENTER     = 5'h05;
  localparam logic [4:0] EV_MULTI     = 5'h0F;
  localparam logic [4:0] EV_HOLD      = 5'h10;
  localparam logic [4:0] EV_HOLD_UP   = 5'h11;
  localparam logic [4:0] EV_HOLD_DOWN = 5'h12;

  // key codes before the hold flag
  localparam logic [3:0] KEY_NONE  = 4'h0;
  localparam logic [3:0] KEY_UP    = 4'h1;
  localparam logic [3:0] KEY_DOWN  = 4'h2;
  localparam logic [3:0] KEY_LEFT  = 4'h3;
  localparam logic [3:0] KEY_RIGHT = 4'h4;
  localparam logic [3:0] KEY_ENTER = 4'h5;
  localparam logic [3:0] KEY_MULTI = 4'hF;

  // beep sequence lengths
  localparam logic [1:0] BEEP_NONE  = 2'd0;
  localparam logic [1:0] BEEP_ONE   = 2'd1;
  localparam logic [1:0] BEEP_TWO   = 2'd2;
  localparam logic [1:0] BEEP_THREE = 2'd3;

  // configuration register indexes
  localparam logic [2:0] REG_PRESS_TICKS    = 3'd0;
  localparam logic [2:0] REG_HOLD_TICKS     = 3'd1;
  localparam logic [2:0] REG_REPEAT_SLOW    = 3'd2;
  localparam logic [2:0] REG_REPEAT_FAST    = 3'd3;
  localparam logic [2:0] REG_SLOW_COUNT     = 3'd4;
  localparam logic [2:0] REG_BEEP_TICKS     = 3'd5;
  localparam logic [2:0] REG_LIGHT_TICKS    = 3'd6;
  localparam logic [2:0] REG_EDIT_TIMEOUT   = 3'd7;

  typedef struct packed {
    logic [4:0] key_lines;
    logic       enable_switch;
    logic       host_load;
    logic [7:0] host_index;
  } kse_in_t;

  typedef struct packed {
    logic [7:0] committed_index;
    logic [7:0] shown_index;
    logic       editing;
    logic       commit_strobe;
    logic       buzzer_on;
    logic       backlight_on;
    logic [4:0] key_event;
  } kse_out_t;

  typedef struct packed {
    logic [15:0] press_ticks;
    logic [15:0] hold_ticks;
    logic [15:0] repeat_slow_ticks;
    logic [15:0] repeat_fast_ticks;
    logic [7:0]  slow_repeat_count;
    logic [15:0] beep_ticks;
    logic [15:0] light_ticks;
    logic [15:0] edit_timeout_ticks;
  } kse_cfg_t;

  // requests from the editor to the buzzer and backlight timers
  typedef struct packed {
    logic       light_req;
    logic       light_clear;
    logic [1:0] beep_req;
  } kse_alert_t;

  // 16-bit timer step that sticks at all ones
  function automatic logic [15:0] kse_sat_inc(input logic [15:0] t);
    return (t == 16'hFFFF) ? t : t + 16'd1;
  endfunction

  // one-hot key lines to key code, several keys give the multi code
  function automatic logic [3:0] kse_code_of(input logic [4:0] lines);
    logic [3:0] code;
    unique case (lines)
      5'b00000: code = KEY_NONE;
      5'b00001: code = KEY_UP;
      5'b00010: code = KEY_DOWN;
      5'b00100: code = KEY_LEFT;
      5'b01000: code = KEY_RIGHT;
      5'b10000: code = KEY_ENTER;
      default:  code = KEY_MULTI;
    endcase
    return code;
  endfunction

endpackage

// ----- hw/rtl/kse_debounce.sv -----
// key debouncer: stable code tracking and press/hold event coding
module kse_debounce (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  logic        scan_i,
  input  logic [4:0]  key_lines_i,
  input  logic [15:0] press_ticks_i,
  input  logic [15:0] hold_ticks_i,
  output logic [4:0]  event_o
);
  import kse_pkg::*;

  logic [3:0]  code_q, code_d;
  logic [15:0] timer_q, timer_d;
  logic [3:0]  sw;

  // event from the code that has been stable so far
  always_comb begin
    sw      = kse_code_of(key_lines_i);
    code_d  = code_q;
    timer_d = kse_sat_inc(timer_q);
    event_o = EV_NONE;
    if (scan_i) begin
      if (code_q != sw) begin
        code_d  = sw;
        timer_d = 16'd1;
      end else begin
        if (timer_q > press_ticks_i) event_o = {1'b0, code_q};
        if (timer_q > hold_ticks_i)  event_o = event_o | EV_HOLD;
      end
    end
  end

  // stable code and its age
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_q  <= KEY_NONE;
      timer_q <= '0;
    end else if (step_i) begin
      code_q  <= code_d;
      timer_q <= timer_d;
    end
  end

endmodule

// ----- hw/rtl/kse_editor.sv -----
// setpoint edit logic: host load, mode, index stepping, auto-repeat, commit, timeout
module kse_editor #(
  parameter int unsigned TableEntries = kse_pkg::TableEntriesDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  logic               enable_i,
  input  logic               load_i,
  input  logic [7:0]         host_index_i,
  input  logic [4:0]         event_i,
  input  kse_pkg::kse_cfg_t  cfg_i,
  output kse_pkg::kse_alert_t alert_o,
  output logic [7:0]         committed_o,
  output logic [7:0]         shown_o,
  output logic               editing_o,
  output logic               strobe_o
);
  import kse_pkg::*;

  localparam logic [7:0] LastIdx = 8'(TableEntries - 1);

  logic [4:0]  last_q, last_d;
  logic        fresh_q, fresh_d;
  logic        seen_q, seen_d;
  logic        edit_q, edit_d;
  logic [7:0]  rcount_q, rcount_d;
  logic        limit_q, limit_d;
  logic [7:0]  saved_q, saved_d;
  logic [7:0]  idx_q, idx_d;
  logic [15:0] change_q, change_d;
  logic [15:0] rtimer_q, rtimer_d;
  logic        change_rst, rtimer_rst;
  logic        room, repeat_due;
  logic [7:0]  stepped, clamped;

  // next state for one tick
  always_comb begin
    last_d     = last_q;
    fresh_d    = fresh_q;
    seen_d     = seen_q;
    edit_d     = edit_q;
    rcount_d   = rcount_q;
    limit_d    = limit_q;
    saved_d    = saved_q;
    idx_d      = idx_q;
    change_rst = 1'b0;
    rtimer_rst = 1'b0;
    alert_o    = '0;
    strobe_o   = 1'b0;
    clamped    = (host_index_i > LastIdx) ? LastIdx : host_index_i;
    room       = event_i[0] ? (idx_q < LastIdx) : (idx_q != 8'd0);
    stepped    = event_i[0] ? idx_q + 8'd1 : idx_q - 8'd1;
    repeat_due = ((rcount_q < cfg_i.slow_repeat_count) &&
                  (rtimer_q > cfg_i.repeat_slow_ticks)) ||
                 ((rcount_q >= cfg_i.slow_repeat_count) &&
                  (rtimer_q > cfg_i.repeat_fast_ticks));
    if (load_i) begin
      saved_d = clamped;
      idx_d   = clamped;
    end else if (enable_i) begin
      if (!seen_q) begin
        alert_o.light_req = 1'b1;
        seen_d            = 1'b1;
      end
      if (last_q != event_i) begin
        last_d  = event_i;
        fresh_d = 1'b1;
      end
      case (event_i) inside
        EV_MULTI: begin
          if (fresh_d) begin
            alert_o.beep_req = BEEP_THREE;
            fresh_d          = 1'b0;
          end
        end
        EV_UP, EV_DOWN: begin
          if (fresh_d) begin
            alert_o.light_req = 1'b1;
            if (edit_q) begin
              rcount_d = '0;
              limit_d  = 1'b0;
              if (room) begin
                alert_o.beep_req = BEEP_ONE;
                idx_d            = stepped;
                change_rst       = 1'b1;
              end else begin
                alert_o.beep_req = BEEP_TWO;
                edit_d           = 1'b0;
              end
            end else begin
              alert_o.beep_req = BEEP_ONE;
            end
            fresh_d = 1'b0;
          end
        end
        EV_HOLD_UP, EV_HOLD_DOWN: begin
          if (repeat_due) begin
            if (rcount_q != 8'hFF) rcount_d = rcount_q + 8'd1;
            rtimer_rst        = 1'b1;
            alert_o.light_req = 1'b1;
            if (room) begin
              idx_d      = stepped;
              change_rst = 1'b1;
              edit_d     = 1'b1;
            end else if (!limit_q) begin
              alert_o.beep_req = BEEP_TWO;
              limit_d          = 1'b1;
            end
          end
        end
        EV_LEFT, EV_RIGHT: begin
          if (fresh_d) begin
            alert_o.light_req = 1'b1;
            alert_o.beep_req  = BEEP_ONE;
            edit_d            = !edit_q;
            fresh_d           = 1'b0;
            change_rst        = 1'b1;
            if (edit_q) idx_d = saved_q;
          end
        end
        EV_ENTER: begin
          if (fresh_d) begin
            alert_o.light_req = 1'b1;
            alert_o.beep_req  = BEEP_ONE;
            saved_d           = idx_q;
            edit_d            = 1'b0;
            strobe_o          = 1'b1;
            fresh_d           = 1'b0;
          end
        end
        default: ;
      endcase
    end else if (seen_q) begin
      seen_d              = 1'b0;
      edit_d              = 1'b0;
      idx_d               = saved_q;
      alert_o.light_clear = 1'b1;
    end
    // tick timers and edit timeout
    change_d = kse_sat_inc(change_rst ? 16'd0 : change_q);
    rtimer_d = kse_sat_inc(rtimer_rst ? 16'd0 : rtimer_q);
    if ((change_d > cfg_i.edit_timeout_ticks) && edit_d) begin
      edit_d = 1'b0;
      idx_d  = saved_d;
    end
  end

  assign committed_o = saved_d;
  assign shown_o     = idx_d;
  assign editing_o   = edit_d;

  // edit state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q   <= EV_NONE;
      fresh_q  <= 1'b0;
      seen_q   <= 1'b0;
      edit_q   <= 1'b0;
      rcount_q <= '0;
      limit_q  <= 1'b0;
      saved_q  <= '0;
      idx_q    <= '0;
      change_q <= '0;
      rtimer_q <= '0;
    end else if (step_i) begin
      last_q   <= last_d;
      fresh_q  <= fresh_d;
      seen_q   <= seen_d;
      edit_q   <= edit_d;
      rcount_q <= rcount_d;
      limit_q  <= limit_d;
      saved_q  <= saved_d;
      idx_q    <= idx_d;
      change_q <= change_d;
      rtimer_q <= rtimer_d;
    end
  end

endmodule

// ----- hw/rtl/kse_annunciator.sv -----
// beep sequencer and backlight timeout
module kse_annunciator (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  kse_pkg::kse_alert_t alert_i,
  input  logic [15:0]         beep_ticks_i,
  input  logic [15:0]         light_ticks_i,
  output logic                buzzer_o,
  output logic                backlight_o
);
  import kse_pkg::*;

  logic        lflag_q, lflag_d;
  logic [15:0] ltimer_q, ltimer_d;
  logic [1:0]  target_q, target_d;
  logic [1:0]  done_q, done_d;
  logic        phase_q, phase_d;
  logic [15:0] btimer_q, btimer_d;
  logic        phase_cur;
  logic [15:0] btimer_cur;

  // backlight: lit on key activity, off after the idle time or switch open
  always_comb begin
    lflag_d = lflag_q;
    if (alert_i.light_clear) lflag_d = 1'b0;
    if (alert_i.light_req)   lflag_d = 1'b1;
    ltimer_d = kse_sat_inc(alert_i.light_req ? 16'd0 : ltimer_q);
    if (ltimer_d >= light_ticks_i) lflag_d = 1'b0;
  end

  // beeps: on phase then off phase per beep, restart on a new request
  always_comb begin
    target_d   = target_q;
    done_d     = done_q;
    phase_cur  = phase_q;
    btimer_cur = btimer_q;
    if (alert_i.beep_req != BEEP_NONE) begin
      target_d   = alert_i.beep_req;
      done_d     = '0;
      phase_cur  = 1'b0;
      btimer_cur = '0;
    end
    phase_d  = phase_cur;
    btimer_d = btimer_cur;
    if (done_d < target_d) begin
      btimer_d = kse_sat_inc(btimer_cur);
      if (btimer_d > beep_ticks_i) begin
        phase_d  = !phase_cur;
        btimer_d = '0;
        if (phase_cur) done_d = done_d + 2'd1;
      end
    end
  end

  assign buzzer_o    = (done_d < target_d) && !phase_d;
  assign backlight_o = lflag_d;

  // timer registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lflag_q  <= 1'b0;
      ltimer_q <= '0;
      target_q <= BEEP_NONE;
      done_q   <= '0;
      phase_q  <= 1'b0;
      btimer_q <= '0;
    end else if (step_i) begin
      lflag_q  <= lflag_d;
      ltimer_q <= ltimer_d;
      target_q <= target_d;
      done_q   <= done_d;
      phase_q  <= phase_d;
      btimer_q <= btimer_d;
    end
  end

endmodule

// ----- hw/rtl/keypad_setpoint_editor.sv -----
// top level of the keypad setpoint editor
// Each input transaction is one timer tick. The tick is captured in an input
// register and worked through in combinational logic into the result register,
// so a tick can be taken every clock cycle unless the result side stalls. The
// debouncer, editor and annunciator registers update once per processed tick.
// Configuration is written through a plain write port (index 0..7); the user
// must write it only while the block is idle, the block does not enforce this.
`include "keypad_setpoint_editor_macros.svh"

module keypad_setpoint_editor #(
  parameter int unsigned TableEntries = kse_pkg::TableEntriesDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  kse_pkg::kse_in_t in_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output kse_pkg::kse_out_t out_o,
  input  logic             cfg_we_i,
  input  logic [2:0]       cfg_idx_i,
  input  logic [15:0]      cfg_data_i
);
  import kse_pkg::*;

  localparam logic [7:0] LastIdx = 8'(TableEntries - 1);

  kse_cfg_t   cfg_q;
  kse_in_t    in_q;
  logic       in_valid_q;
  kse_out_t   out_q, res;
  logic       out_valid_q;
  logic       step, scan;
  logic [4:0] key_event;
  kse_alert_t alert;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.press_ticks        <= 16'd5;
      cfg_q.hold_ticks         <= 16'd100;
      cfg_q.repeat_slow_ticks  <= 16'd50;
      cfg_q.repeat_fast_ticks  <= 16'd10;
      cfg_q.slow_repeat_count  <= 8'd5;
      cfg_q.beep_ticks         <= 16'd10;
      cfg_q.light_ticks        <= 16'd1000;
      cfg_q.edit_timeout_ticks <= 16'd3000;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_PRESS_TICKS:  cfg_q.press_ticks        <= cfg_data_i;
        REG_HOLD_TICKS:   cfg_q.hold_ticks         <= cfg_data_i;
        REG_REPEAT_SLOW:  cfg_q.repeat_slow_ticks  <= cfg_data_i;
        REG_REPEAT_FAST:  cfg_q.repeat_fast_ticks  <= cfg_data_i;
        REG_SLOW_COUNT:   cfg_q.slow_repeat_count  <= cfg_data_i[7:0];
        REG_BEEP_TICKS:   cfg_q.beep_ticks         <= cfg_data_i;
        REG_LIGHT_TICKS:  cfg_q.light_ticks        <= cfg_data_i;
        REG_EDIT_TIMEOUT: cfg_q.edit_timeout_ticks <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // the held tick is processed when the result register can take it
  assign step       = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || step;
  assign scan       = !in_q.host_load && in_q.enable_switch;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      in_valid_q <= 1'b1;
    end else if (step) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_i;
    end
  end

  kse_debounce u_debounce (
    .clk_i,
    .rst_ni,
    .step_i        (step),
    .scan_i        (scan),
    .key_lines_i   (in_q.key_lines),
    .press_ticks_i (cfg_q.press_ticks),
    .hold_ticks_i  (cfg_q.hold_ticks),
    .event_o       (key_event)
  );

  kse_editor #(
    .TableEntries (TableEntries)
  ) u_editor (
    .clk_i,
    .rst_ni,
    .step_i       (step),
    .enable_i     (in_q.enable_switch),
    .load_i       (in_q.host_load),
    .host_index_i (in_q.host_index),
    .event_i      (key_event),
    .cfg_i        (cfg_q),
    .alert_o      (alert),
    .committed_o  (res.committed_index),
    .shown_o      (res.shown_index),
    .editing_o    (res.editing),
    .strobe_o     (res.commit_strobe)
  );

  kse_annunciator u_annunciator (
    .clk_i,
    .rst_ni,
    .step_i        (step),
    .alert_i       (alert),
    .beep_ticks_i  (cfg_q.beep_ticks),
    .light_ticks_i (cfg_q.light_ticks),
    .buzzer_o      (res.buzzer_on),
    .backlight_o   (res.backlight_on)
  );

  assign res.key_event = key_event;

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // checks
  `KSE_ASSERT_NEXT(a_accept_fills_stage, in_valid_i && in_ready_o, in_valid_q)
  `KSE_ASSERT_NOW(a_commit_leaves_edit, out_valid_o && out_o.commit_strobe, !out_o.editing)
  `KSE_ASSERT_NOW(a_index_in_table, out_valid_o,
    (out_o.shown_index <= LastIdx) && (out_o.committed_index <= LastIdx))

endmodule

// ----- tb/setpoint_checker.sv -----
// transaction monitor with its own panel editor model, compares every result against it
`timescale 1ns / 100ps

module setpoint_checker #(
  parameter int unsigned TableEntries = kse_pkg::TableEntriesDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  kse_pkg::kse_in_t  in_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  kse_pkg::kse_out_t out_i,
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_idx_i,
  input  logic [15:0]       cfg_data_i,
  output int                pending_o,
  output int                errors_o
);
  import kse_pkg::*;

  localparam logic [7:0] LAST_ENTRY = 8'(TableEntries - 1);

  // register copy
  kse_cfg_t cfg;

  // debouncer, editor and annunciator state
  logic [3:0]  held_key;
  logic [15:0] stable_tmr, repeat_tmr, change_tmr, light_tmr, beep_tmr;
  logic [4:0]  last_ev;
  logic        ev_fresh, switch_on, edit_on, bound_beeped, light_on, beep_gap;
  logic [7:0]  rpt_cnt, stored_idx, shown_idx;
  logic [1:0]  beep_goal, beeps_done;

  kse_out_t    due_panel_states[$];
  int          mismatch_count = 0;

  assign errors_o = mismatch_count;

  task automatic note_error(input string msg);
    $display("%0t ns mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [7:0] got,
                             input logic [7:0] want);
    if (got !== want) note_error($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  // timers stop at all ones
  function automatic logic [15:0] tick16(input logic [15:0] t);
    return t + {15'd0, ~&t};
  endfunction

  function automatic logic [3:0] key_from_lines(input logic [4:0] lines);
    if (lines == 5'd0) return KEY_NONE;
    if ($countones(lines) > 1) return KEY_MULTI;
    if (lines[0]) return KEY_UP;
    if (lines[1]) return KEY_DOWN;
    if (lines[2]) return KEY_LEFT;
    if (lines[3]) return KEY_RIGHT;
    return KEY_ENTER;
  endfunction

  // one tick of the panel: keys or host load first, then the timers
  task automatic advance_panel(input kse_in_t t, output kse_out_t r);
    logic [4:0] ev;
    logic [1:0] beep_ask;
    logic       strobe, light_ask, room;
    logic [3:0] key;
    ev = EV_NONE;
    beep_ask = BEEP_NONE;
    strobe = 1'b0;
    light_ask = 1'b0;
    if (t.host_load) begin
      stored_idx = (t.host_index > LAST_ENTRY) ? LAST_ENTRY : t.host_index;
      shown_idx = stored_idx;
    end else if (t.enable_switch) begin
      key = key_from_lines(t.key_lines);
      if (!switch_on) begin
        light_ask = 1'b1;
        switch_on = 1'b1;
      end
      // debounce, hold flag on top of the press code
      if (held_key != key) begin
        held_key = key;
        stable_tmr = 16'd0;
      end else begin
        if (stable_tmr > cfg.press_ticks) ev = {1'b0, held_key};
        if (stable_tmr > cfg.hold_ticks) ev = ev | EV_HOLD;
      end
      if (last_ev != ev) begin
        last_ev = ev;
        ev_fresh = 1'b1;
      end
      case (ev)
        EV_MULTI: if (ev_fresh) begin
          beep_ask = BEEP_THREE;
          ev_fresh = 1'b0;
        end
        EV_UP, EV_DOWN: if (ev_fresh) begin
          light_ask = 1'b1;
          if (edit_on) begin
            room = (ev == EV_UP) ? (shown_idx < LAST_ENTRY) : (shown_idx > 8'd0);
            rpt_cnt = 8'd0;
            bound_beeped = 1'b0;
            edit_on = 1'b0;
            if (room) begin
              beep_ask = BEEP_ONE;
              shown_idx = (ev == EV_UP) ? shown_idx + 8'd1 : shown_idx - 8'd1;
              change_tmr = 16'd0;
              edit_on = 1'b1;
            end else begin
              beep_ask = BEEP_TWO;
            end
          end else begin
            beep_ask = BEEP_ONE;
          end
          ev_fresh = 1'b0;
        end
        // auto-repeat: slow interval first, fast once the slow repeats are used
        EV_HOLD_UP, EV_HOLD_DOWN: begin
          if ((rpt_cnt < cfg.slow_repeat_count && repeat_tmr > cfg.repeat_slow_ticks) ||
              ({1'b0, rpt_cnt} + 9'd1 > {1'b0, cfg.slow_repeat_count} &&
               repeat_tmr > cfg.repeat_fast_ticks)) begin
            room = (ev == EV_HOLD_UP) ? (shown_idx < LAST_ENTRY) : (shown_idx > 8'd0);
            if (rpt_cnt != 8'hFF) rpt_cnt = rpt_cnt + 8'd1;
            repeat_tmr = 16'd0;
            light_ask = 1'b1;
            if (room) begin
              shown_idx = (ev == EV_HOLD_UP) ? shown_idx + 8'd1 : shown_idx - 8'd1;
              change_tmr = 16'd0;
              edit_on = 1'b1;
            end else if (!bound_beeped) begin
              beep_ask = BEEP_TWO;
              bound_beeped = 1'b1;
            end
          end
        end
        EV_LEFT, EV_RIGHT: if (ev_fresh) begin
          light_ask = 1'b1;
          beep_ask = BEEP_ONE;
          edit_on = !edit_on;
          ev_fresh = 1'b0;
          change_tmr = 16'd0;
          if (!edit_on) shown_idx = stored_idx;
        end
        EV_ENTER: if (ev_fresh) begin
          light_ask = 1'b1;
          beep_ask = BEEP_ONE;
          stored_idx = shown_idx;
          edit_on = 1'b0;
          strobe = 1'b1;
          ev_fresh = 1'b0;
        end
        default: ;
      endcase
    end else if (switch_on) begin
      // switch opened: drop the edit and the backlight
      switch_on = 1'b0;
      edit_on = 1'b0;
      shown_idx = stored_idx;
      light_on = 1'b0;
    end

    if (light_ask) light_on = 1'b1;

    // tick timers
    stable_tmr = tick16(stable_tmr);
    repeat_tmr = tick16(repeat_tmr);
    if (light_ask) light_tmr = 16'd0;
    light_tmr = tick16(light_tmr);
    if (light_tmr >= cfg.light_ticks) light_on = 1'b0;
    change_tmr = tick16(change_tmr);
    if (change_tmr > cfg.edit_timeout_ticks && edit_on) begin
      edit_on = 1'b0;
      shown_idx = stored_idx;
    end

    // beep sequencer, a new request restarts it
    if (beep_ask != BEEP_NONE) begin
      beep_goal = beep_ask;
      beeps_done = 2'd0;
      beep_tmr = 16'd0;
      beep_gap = 1'b0;
    end
    if (beeps_done < beep_goal) begin
      beep_tmr = tick16(beep_tmr);
      if (!beep_gap && beep_tmr > cfg.beep_ticks) begin
        beep_gap = 1'b1;
        beep_tmr = 16'd0;
      end
      if (beep_gap && beep_tmr > cfg.beep_ticks) begin
        beep_gap = 1'b0;
        beep_tmr = 16'd0;
        beeps_done = beeps_done + 2'd1;
      end
    end

    r.committed_index = stored_idx;
    r.shown_index = shown_idx;
    r.editing = edit_on;
    r.commit_strobe = strobe;
    r.buzzer_on = (beeps_done < beep_goal) && !beep_gap;
    r.backlight_on = light_on;
    r.key_event = ev;
  endtask

  // watch config writes and both channels
  always @(posedge clk_i or negedge rst_ni) begin
    kse_out_t want;
    kse_out_t got;
    if (!rst_ni) begin
      cfg.press_ticks = 16'd5;
      cfg.hold_ticks = 16'd100;
      cfg.repeat_slow_ticks = 16'd50;
      cfg.repeat_fast_ticks = 16'd10;
      cfg.slow_repeat_count = 8'd5;
      cfg.beep_ticks = 16'd10;
      cfg.light_ticks = 16'd1000;
      cfg.edit_timeout_ticks = 16'd3000;
      held_key = KEY_NONE;
      {stable_tmr, repeat_tmr, change_tmr, light_tmr, beep_tmr} = '0;
      last_ev = EV_NONE;
      {ev_fresh, switch_on, edit_on, bound_beeped, light_on, beep_gap} = '0;
      {rpt_cnt, stored_idx, shown_idx} = '0;
      beep_goal = BEEP_NONE;
      beeps_done = 2'd0;
      due_panel_states.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_PRESS_TICKS:  cfg.press_ticks = cfg_data_i;
          REG_HOLD_TICKS:   cfg.hold_ticks = cfg_data_i;
          REG_REPEAT_SLOW:  cfg.repeat_slow_ticks = cfg_data_i;
          REG_REPEAT_FAST:  cfg.repeat_fast_ticks = cfg_data_i;
          REG_SLOW_COUNT:   cfg.slow_repeat_count = cfg_data_i[7:0];
          REG_BEEP_TICKS:   cfg.beep_ticks = cfg_data_i;
          REG_LIGHT_TICKS:  cfg.light_ticks = cfg_data_i;
          REG_EDIT_TIMEOUT: cfg.edit_timeout_ticks = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        advance_panel(in_i, want);
        due_panel_states.push_back(want);
      end
      if (out_valid_i && out_ready_i) begin
        got = out_i;
        if (due_panel_states.size() == 0) begin
          note_error("result transaction with nothing expected");
        end else begin
          want = due_panel_states.pop_front();
          check_field("committed_index", got.committed_index, want.committed_index);
          check_field("shown_index", got.shown_index, want.shown_index);
          check_field("editing", 8'(got.editing), 8'(want.editing));
          check_field("commit_strobe", 8'(got.commit_strobe), 8'(want.commit_strobe));
          check_field("buzzer_on", 8'(got.buzzer_on), 8'(want.buzzer_on));
          check_field("backlight_on", 8'(got.backlight_on), 8'(want.backlight_on));
          check_field("key_event", 8'(got.key_event), 8'(want.key_event));
        end
      end
      pending_o <= due_panel_states.size();
    end
  end

endmodule

// ----- tb/testbench.sv -----
// top of the keypad setpoint editor testbench: clock, reset, tick stimulus and verdict
`timescale 1ns / 100ps

module testbench;
  import kse_pkg::*;

  localparam logic [4:0] LINE_NONE  = 5'b00000;
  localparam logic [4:0] LINE_UP    = 5'b00001;
  localparam logic [4:0] LINE_DOWN  = 5'b00010;
  localparam logic [4:0] LINE_LEFT  = 5'b00100;
  localparam logic [4:0] LINE_RIGHT = 5'b01000;
  localparam logic [4:0] LINE_ENTER = 5'b10000;

  localparam int SETTLE_CYCLES = 8;

  // register settings of the phases
  localparam kse_cfg_t DIRECTED_SET = '{press_ticks: 16'd0, hold_ticks: 16'd3,
    repeat_slow_ticks: 16'd1, repeat_fast_ticks: 16'd0, slow_repeat_count: 8'd2,
    beep_ticks: 16'd1, light_ticks: 16'd6, edit_timeout_ticks: 16'd10};
  localparam kse_cfg_t BRISK_SET = '{press_ticks: 16'd1, hold_ticks: 16'd6,
    repeat_slow_ticks: 16'd3, repeat_fast_ticks: 16'd1, slow_repeat_count: 8'd3,
    beep_ticks: 16'd2, light_ticks: 16'd40, edit_timeout_ticks: 16'd60};
  localparam kse_cfg_t ZERO_SET = '0;
  localparam kse_cfg_t LONG_REPEAT_SET = '{press_ticks: 16'd2, hold_ticks: 16'd4,
    repeat_slow_ticks: 16'd0, repeat_fast_ticks: 16'd1, slow_repeat_count: 8'd255,
    beep_ticks: 16'd3, light_ticks: 16'd100, edit_timeout_ticks: 16'd200};
  localparam kse_cfg_t SOAK_SET = '{press_ticks: 16'd0, hold_ticks: 16'hFFFF,
    repeat_slow_ticks: 16'hFFFF, repeat_fast_ticks: 16'hFFFF, slow_repeat_count: 8'd0,
    beep_ticks: 16'hFFFF, light_ticks: 16'hFFFF, edit_timeout_ticks: 16'hFFFF};
  localparam kse_cfg_t MAX_SET = '1;
  localparam kse_cfg_t DEFAULT_SET = '{press_ticks: 16'd5, hold_ticks: 16'd100,
    repeat_slow_ticks: 16'd50, repeat_fast_ticks: 16'd10, slow_repeat_count: 8'd5,
    beep_ticks: 16'd10, light_ticks: 16'd1000, edit_timeout_ticks: 16'd3000};

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready_o;
  kse_in_t     in_item;
  logic        out_valid_o;
  logic        out_ready = 1'b0;
  kse_out_t    out_o;
  logic        cfg_we;
  logic [2:0]  cfg_idx;
  logic [15:0] cfg_data;
  logic        calm = 1'b0;
  int          pending;
  int          errors;
  int unsigned sent_ticks = 0;

  keypad_setpoint_editor uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_i        (in_item),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_o       (out_o),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  setpoint_checker #(.TableEntries(kse_pkg::TableEntriesDef)) panel_watch (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready_o),
    .in_i        (in_item),
    .out_valid_i (out_valid_o),
    .out_ready_i (out_ready),
    .out_i       (out_o),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .pending_o   (pending),
    .errors_o    (errors)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // run limit
  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

  // result side stalls at random unless in a calm stretch
  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(0, 99) >= 11);
  end

  // one tick transaction, with an occasional idle cycle ahead of it
  task automatic send_tick(input kse_in_t t);
    if (!calm && $urandom_range(0, 99) < 11) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= t;
    @(posedge clk);
    while (!in_ready_o) @(posedge clk);
    sent_ticks++;
  endtask

  task automatic hold_key(input logic [4:0] lines, input int unsigned ticks);
    kse_in_t t;
    t = '0;
    t.key_lines = lines;
    t.enable_switch = 1'b1;
    repeat (ticks) send_tick(t);
  endtask

  // stop sending and wait for every expected result
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  task automatic apply_settings(input kse_cfg_t s);
    write_reg(REG_PRESS_TICKS, s.press_ticks);
    write_reg(REG_HOLD_TICKS, s.hold_ticks);
    write_reg(REG_REPEAT_SLOW, s.repeat_slow_ticks);
    write_reg(REG_REPEAT_FAST, s.repeat_fast_ticks);
    write_reg(REG_SLOW_COUNT, {8'd0, s.slow_repeat_count});
    write_reg(REG_BEEP_TICKS, s.beep_ticks);
    write_reg(REG_LIGHT_TICKS, s.light_ticks);
    write_reg(REG_EDIT_TIMEOUT, s.edit_timeout_ticks);
    cfg_we <= 1'b0;
  endtask

  // one random stretch: mostly single key presses held for a while, the rest
  // releases, chords, host loads, switch openings and noise
  task automatic random_burst(input int unsigned maxlen);
    kse_in_t     t;
    int unsigned pick, len;
    pick = $urandom_range(0, 99);
    len = $urandom_range(1, maxlen);
    t = '0;
    t.enable_switch = 1'b1;
    t.host_index = 8'($urandom_range(0, 255));
    if (pick < 62) begin
      case ($urandom_range(0, 9))
        0, 1, 2: t.key_lines = LINE_UP;
        3, 4, 5: t.key_lines = LINE_DOWN;
        6:       t.key_lines = LINE_LEFT;
        7:       t.key_lines = LINE_RIGHT;
        default: t.key_lines = LINE_ENTER;
      endcase
      repeat (len) send_tick(t);
      // usually let go so the next press is fresh
      t.key_lines = LINE_NONE;
      repeat ($urandom_range(0, 3)) send_tick(t);
    end else if (pick < 70) begin
      t.key_lines = LINE_NONE;
      repeat (len) send_tick(t);
    end else if (pick < 78) begin
      t.key_lines = 5'($urandom_range(0, 31));
      repeat (len) send_tick(t);
    end else if (pick < 86) begin
      t.host_load = 1'b1;
      t.key_lines = 5'($urandom_range(0, 31));
      t.enable_switch = 1'($urandom_range(0, 1));
      send_tick(t);
    end else if (pick < 92) begin
      t.enable_switch = 1'b0;
      t.key_lines = 5'($urandom_range(0, 31));
      repeat (len) send_tick(t);
    end else begin
      repeat (len) begin
        t.key_lines = 5'($urandom());
        t.enable_switch = 1'($urandom());
        t.host_index = 8'($urandom());
        t.host_load = ($urandom_range(0, 9) == 0);
        send_tick(t);
      end
    end
  endtask

  task automatic random_phase(input int unsigned ticks, input int unsigned maxlen);
    int unsigned start;
    start = sent_ticks;
    while (sent_ticks - start < ticks) random_burst(maxlen);
  endtask

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_item <= '0;
    cfg_we <= 1'b0;
    cfg_idx <= REG_PRESS_TICKS;
    cfg_data <= 16'd0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: host load clamp, keys ignored under a load, every key,
    // hold step out of edit mode, fresh and held steps at the lower bound,
    // chord, commit and switch opening
    apply_settings(DIRECTED_SET);
    send_tick(kse_in_t'{key_lines: 5'h1F, enable_switch: 1'b1, host_load: 1'b1,
                        host_index: 8'hFF});
    send_tick(kse_in_t'{key_lines: LINE_NONE, enable_switch: 1'b0, host_load: 1'b1,
                        host_index: 8'h00});
    hold_key(LINE_UP, 6);
    hold_key(LINE_NONE, 1);
    hold_key(LINE_DOWN, 2);
    hold_key(LINE_NONE, 1);
    hold_key(LINE_DOWN, 6);
    hold_key(LINE_LEFT, 2);
    hold_key(LINE_RIGHT, 2);
    hold_key(LINE_ENTER, 2);
    hold_key(LINE_UP | LINE_ENTER, 2);
    send_tick(kse_in_t'{key_lines: LINE_NONE, enable_switch: 1'b0, host_load: 1'b0,
                        host_index: 8'h00});
    settle();

    apply_settings(BRISK_SET);
    random_phase(200, 30);
    settle();

    // all-zero registers, no idling on either side
    apply_settings(ZERO_SET);
    calm <= 1'b1;
    random_phase(150, 12);
    settle();
    calm <= 1'b0;

    // long hold drives the repeat counter to its ceiling
    apply_settings(LONG_REPEAT_SET);
    hold_key(LINE_DOWN, 300);
    random_phase(60, 25);
    settle();

    // near-maximum intervals while one key stays down
    apply_settings(SOAK_SET);
    hold_key(LINE_LEFT, 3);
    hold_key(LINE_UP, 40);
    settle();

    apply_settings(MAX_SET);
    random_phase(50, 10);
    settle();

    apply_settings(DEFAULT_SET);
    random_phase(80, 60);
    settle();

    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- keypad_setpoint_editor.f -----
+incdir+hw/rtl
hw/rtl/kse_pkg.sv
hw/rtl/kse_debounce.sv
hw/rtl/kse_editor.sv
hw/rtl/kse_annunciator.sv
hw/rtl/keypad_setpoint_editor.sv
tb/setpoint_checker.sv
tb/testbench.sv
